FILE: design/sarw_pkg.sv
// Shared types and constants for the session anti-replay window block.
// Used by the state memory and the top level; depends on nothing else.
package sarw_pkg;

    localparam int SLOT_W      = 8;
    localparam int SEQ_W       = 64;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 8;
    localparam int SLOT_CODES  = 256;

    typedef enum logic [2:0] {
        VERDICT_NEW  = 3'd0,
        VERDICT_OOO  = 3'd1,
        VERDICT_ZERO = 3'd2,
        VERDICT_OLD  = 3'd3,
        VERDICT_DUP  = 3'd4
    } t_verdict;

endpackage

FILE: design/session_anti_replay_window.sv
// Result path: an accepted input word is registered in the stage-1 registers while its slot
// is read, and its result word is registered in the output register once that register is free.
// Throughput: one word per cycle unless the output stalls; each word does one read-modify-write
// of its slot in the state memory, the write-back forwarded to a following word on the same slot.
// Reset: synchronous, active low; every slot's valid bit clears at once, so all slots
// read as zero right after reset and no clearing pass is needed. Depends on sarw_pkg, sarw_state_ram.
module session_anti_replay_window
    import sarw_pkg::*;
#(
    parameter int SESSION_SLOTS = 256,
    parameter int WINDOW_BITS   = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // session_slot[7:0], sequence_req[71:8]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata   // reject[0], verdict[3:1], zero[7:4]
);

    localparam int DEPTH = (SESSION_SLOTS < SLOT_CODES) ? SESSION_SLOTS : SLOT_CODES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = SEQ_W + WINDOW_BITS;
    localparam int SH_W  = $clog2(WINDOW_BITS);

    logic [AW-1:0] slot_map [SLOT_CODES];

    for (genvar g = 0; g < SLOT_CODES; g++) begin : g_slot_map
        localparam int Mapped = g % DEPTH;
        assign slot_map[g] = AW'(Mapped);
    end

    logic              s_accept;
    logic              s1_adv;
    logic [AW-1:0]     in_addr;
    logic [SEQ_W-1:0]  in_seq;

    logic              r_s1_vld;
    logic [AW-1:0]     r_s1_addr;
    logic [SEQ_W-1:0]  r_s1_seq;
    logic              r_byp;
    logic [DW-1:0]     r_byp_data;

    logic              r_m_vld;
    logic [M_TDATA_W-1:0] r_m_data;

    logic [DW-1:0]          rd_data;
    logic [DW-1:0]          cur;
    logic [SEQ_W-1:0]       top;
    logic [WINDOW_BITS-1:0] win;
    logic [SEQ_W-1:0]       up_dist;
    logic [SEQ_W-1:0]       dn_dist;
    logic [SEQ_W-1:0]       n_top;
    logic [WINDOW_BITS-1:0] n_win;
    t_verdict               n_verdict;
    logic                   n_reject;
    logic [DW-1:0]          wr_data;

    assign in_addr  = slot_map[i_s_tdata[SLOT_W-1:0]];
    assign in_seq   = i_s_tdata[SLOT_W +: SEQ_W];
    assign s1_adv   = r_s1_vld && (!r_m_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || s1_adv;
    assign s_accept = i_s_tvalid && o_s_tready;

    sarw_state_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_accept),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_data)
    );

    assign cur     = r_byp ? r_byp_data : rd_data;
    assign top     = cur[SEQ_W-1:0];
    assign win     = cur[DW-1:SEQ_W];
    assign up_dist = r_s1_seq - top;
    assign dn_dist = top - r_s1_seq;

    always_comb begin
        n_top     = top;
        n_win     = win;
        n_verdict = VERDICT_NEW;
        if (r_s1_seq == '0) begin
            n_verdict = VERDICT_ZERO;
        end else if (r_s1_seq > top) begin
            n_verdict = VERDICT_NEW;
            n_top     = r_s1_seq;
            if (up_dist < SEQ_W'(WINDOW_BITS)) begin
                n_win = (win << up_dist[SH_W-1:0]) | WINDOW_BITS'(1);
            end else begin
                n_win = WINDOW_BITS'(1);
            end
        end else if (dn_dist >= SEQ_W'(WINDOW_BITS)) begin
            n_verdict = VERDICT_OLD;
        end else if (win[dn_dist[SH_W-1:0]]) begin
            n_verdict = VERDICT_DUP;
        end else begin
            n_verdict = VERDICT_OOO;
            n_win[dn_dist[SH_W-1:0]] = 1'b1;
        end
        n_reject = !((n_verdict == VERDICT_NEW) || (n_verdict == VERDICT_OOO));
    end

    assign wr_data = {n_win, n_top};

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_addr  <= in_addr;
            r_s1_seq   <= in_seq;
            r_byp_data <= wr_data;
        end
        if (s1_adv) begin
            r_m_data <= {4'b0000, n_verdict, n_reject};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_byp    <= 1'b0;
            r_m_vld  <= 1'b0;
        end else begin
            if (s_accept) begin
                r_s1_vld <= 1'b1;
                r_byp    <= s1_adv && (r_s1_addr == in_addr);
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_m_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_m_vld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_m_vld;
    assign o_m_tdata  = r_m_data;

endmodule

FILE: design/sarw_state_ram.sv
// Per-slot state memory with one write port and one registered read port.
// Each entry has a valid bit cleared by reset; an unwritten entry reads as zero.
// Depends on sarw_pkg.
module sarw_state_ram
    import sarw_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld_bits;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_bits <= '0;
            r_rd_ok    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld_bits[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_vld_bits[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule
